FILE: rtl/ir_distance_average_lut_defines.svh
// assertion macros shared by the rtl files
`ifndef IR_DISTANCE_AVERAGE_LUT_DEFINES_SVH
`define IR_DISTANCE_AVERAGE_LUT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define IDAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define IDAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/idal_pkg.sv
// shared types, calibration curves and constants for the ir distance block
`default_nettype none

package idal_pkg;

  localparam int SID_W     = 2;
  localparam int NUM_SLOTS = 4;
  localparam int CFG_W     = 4;
  localparam logic [CFG_W-1:0] CURVE_MAP_RESET = 4'd8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  // word index of the register
  localparam logic [APB_ADDR_W-3:0] REG_CURVE_SELECT = 1'd0;

  localparam int AVG_W  = 16;
  localparam int DIST_W = 12;
  localparam logic [DIST_W-1:0] DIST_NEAR = 12'd80;
  localparam logic [DIST_W-1:0] DIST_FAR  = 12'd3200;
  localparam logic [DIST_W-1:0] DIST_STEP = 12'd80;

  localparam int BP_W      = 18;  // breakpoints in hundredths
  localparam int X_W       = 21;  // reading times 400
  localparam int NUM_W     = 29;  // interpolation dividend
  localparam int FRAC_BITS = 7;   // fraction 0..80
  localparam int IDX_W     = 6;

  localparam int CURVE_A_LEN   = 39;
  localparam int CURVE_B_LEN   = 37;
  localparam int CURVE_MAX_LEN = 39;

  localparam logic [BP_W-1:0] CURVE_A [CURVE_A_LEN] = '{
    18'd135600, 18'd123000, 18'd98000, 18'd78300, 18'd63300, 18'd49400, 18'd37000,
    18'd29800, 18'd23000, 18'd18900, 18'd15600, 18'd12800, 18'd11100, 18'd9400,
    18'd8200, 18'd7000, 18'd5800, 18'd5000, 18'd4300, 18'd3989, 18'd3380, 18'd3014,
    18'd2760, 18'd2390, 18'd2290, 18'd1970, 18'd1800, 18'd1500, 18'd1400, 18'd1280,
    18'd1160, 18'd1060, 18'd930, 18'd880, 18'd810, 18'd760, 18'd700, 18'd620,
    18'd580
  };

  localparam logic [BP_W-1:0] CURVE_B [CURVE_B_LEN] = '{
    18'd104300, 18'd97000, 18'd85000, 18'd74300, 18'd63700, 18'd55500, 18'd48100,
    18'd42200, 18'd36300, 18'd32200, 18'd28200, 18'd25000, 18'd22400, 18'd20100,
    18'd18000, 18'd16200, 18'd14700, 18'd13500, 18'd12400, 18'd11300, 18'd10300,
    18'd9400, 18'd8700, 18'd8000, 18'd7400, 18'd6800, 18'd6300, 18'd5800, 18'd5400,
    18'd5000, 18'd4600, 18'd4300, 18'd4000, 18'd3700, 18'd3400, 18'd3200, 18'd3000
  };

  // breakpoint scaled by 4, zero past the end of the curve
  function automatic logic [X_W-1:0] curve_bp4(input logic second,
                                               input logic [IDX_W-1:0] idx);
    logic [BP_W-1:0] v;
    v = '0;
    if (second) begin
      if (idx < IDX_W'(CURVE_B_LEN)) begin
        v = CURVE_B[idx];
      end
    end else begin
      if (idx < IDX_W'(CURVE_A_LEN)) begin
        v = CURVE_A[idx];
      end
    end
    return X_W'({v, 2'b00});
  endfunction

  typedef struct packed {
    logic [SID_W-1:0] sensor;
    logic [AVG_W-1:0] avg;
    logic             second;
  } interp_req_t;

  typedef struct packed {
    logic [SID_W-1:0] sensor;
    logic [AVG_W-1:0] avg;
    logic             second;
    logic             near;
    logic             far;
    logic [IDX_W-1:0] count;
    logic [X_W-1:0]   x;
  } cmp_stage_t;

  typedef struct packed {
    logic [SID_W-1:0]  sensor;
    logic [AVG_W-1:0]  avg;
    logic              near;
    logic              far;
    logic [DIST_W-1:0] base;
    logic [X_W-1:0]    d;
    logic [X_W-1:0]    den;
  } seg_stage_t;

  typedef struct packed {
    logic [SID_W-1:0]     sensor;
    logic [AVG_W-1:0]     avg;
    logic                 near;
    logic                 far;
    logic [DIST_W-1:0]    base;
    logic [NUM_W-1:0]     rem;
    logic [X_W:0]         div2;
    logic [FRAC_BITS-1:0] quot;
  } div_stage_t;

  typedef struct packed {
    logic [SID_W-1:0]  sensor;
    logic [DIST_W-1:0] distance;
    logic [AVG_W-1:0]  avg;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/idal_interp.sv
// breakpoint search and piecewise-linear interpolation pipeline
`default_nettype none
`include "ir_distance_average_lut_defines.svh"

module idal_interp
  import idal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  interp_req_t req,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  localparam int NSTG   = FRAC_BITS + 3;
  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_D0  = 2;
  localparam int ST_OUT = NSTG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] load;

  cmp_stage_t sa, sa_next;
  seg_stage_t sb, sb_next;
  div_stage_t d0_next;
  div_stage_t dstg    [FRAC_BITS];
  div_stage_t stepped [FRAC_BITS];
  result_t    out_q, out_next;

  logic [X_W-1:0]           a_x;
  logic [IDX_W-1:0]         a_len;
  logic [IDX_W-1:0]         a_cnt;
  logic [CURVE_MAX_LEN-1:0] a_lt;
  logic [X_W-1:0]           b_hi;
  logic [X_W-1:0]           b_lo;

  function automatic div_stage_t div_step(input div_stage_t s, input int unsigned bit_pos);
    div_stage_t       r;
    logic [NUM_W-1:0] trial;
    r = s;
    trial = NUM_W'(s.div2) << bit_pos;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.quot = s.quot | (FRAC_BITS'(1) << bit_pos);
    end
    return r;
  endfunction

  // a stage loads when empty or when the next one loads
  always_comb begin
    load[ST_OUT] = !vld[ST_OUT] || res_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // compare against every breakpoint of the chosen curve
  always_comb begin
    a_x   = X_W'(req.avg) * X_W'(25);
    a_len = req.second ? IDX_W'(CURVE_B_LEN) : IDX_W'(CURVE_A_LEN);
    for (int j = 0; j < CURVE_MAX_LEN; j++) begin
      a_lt[j] = (IDX_W'(j) < a_len) && (a_x < curve_bp4(req.second, IDX_W'(j)));
    end
    // falling curve: a_lt is a run of ones from bit 0, locate its end
    a_cnt = '0;
    for (int j = 1; j < CURVE_MAX_LEN; j++) begin
      if (a_lt[j-1] && !a_lt[j]) begin
        a_cnt = a_cnt | IDX_W'(j);
      end
    end
    if (a_lt[CURVE_MAX_LEN-1]) begin
      a_cnt = a_cnt | IDX_W'(CURVE_MAX_LEN);
    end
    sa_next.sensor = req.sensor;
    sa_next.avg    = req.avg;
    sa_next.second = req.second;
    sa_next.near   = (a_cnt == '0);
    sa_next.far    = (a_cnt == a_len);
    sa_next.count  = a_cnt;
    sa_next.x      = a_x;
  end

  // segment endpoints and offset into the segment
  always_comb begin
    b_hi = curve_bp4(sa.second, sa.count - IDX_W'(1));
    b_lo = curve_bp4(sa.second, sa.count);
    sb_next.sensor = sa.sensor;
    sb_next.avg    = sa.avg;
    sb_next.near   = sa.near;
    sb_next.far    = sa.far;
    sb_next.base   = DIST_W'(sa.count) * DIST_STEP;
    sb_next.d      = b_hi - sa.x;
    sb_next.den    = b_hi - b_lo;
  end

  // round to nearest: (160*d + den) / (2*den)
  always_comb begin
    d0_next.sensor = sb.sensor;
    d0_next.avg    = sb.avg;
    d0_next.near   = sb.near;
    d0_next.far    = sb.far;
    d0_next.base   = sb.base;
    d0_next.rem    = NUM_W'(sb.d) * NUM_W'(160) + NUM_W'(sb.den);
    d0_next.div2   = {sb.den, 1'b0};
    d0_next.quot   = '0;
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
    assign stepped[j] = div_step(dstg[j], FRAC_BITS - 1 - j);
  end

  always_comb begin
    out_next.sensor = stepped[FRAC_BITS-1].sensor;
    out_next.avg    = stepped[FRAC_BITS-1].avg;
    priority if (stepped[FRAC_BITS-1].far) begin
      out_next.distance = DIST_FAR;
    end else if (stepped[FRAC_BITS-1].near) begin
      out_next.distance = DIST_NEAR;
    end else begin
      out_next.distance = stepped[FRAC_BITS-1].base + DIST_W'(stepped[FRAC_BITS-1].quot);
    end
  end

  always_ff @(posedge clk) begin
    if (load[ST_A]) begin
      sa <= sa_next;
    end
    if (load[ST_B]) begin
      sb <= sb_next;
    end
    if (load[ST_D0]) begin
      dstg[0] <= d0_next;
    end
    for (int j = 1; j < FRAC_BITS; j++) begin
      if (load[ST_D0+j]) begin
        dstg[j] <= stepped[j-1];
      end
    end
    if (load[ST_OUT]) begin
      out_q <= out_next;
    end
  end

  assign req_ready = load[0];
  assign res_valid = vld[ST_OUT];
  assign res       = out_q;

  `IDAL_ASSERT_SAME(a_dist_range, res_valid, (res.distance >= DIST_NEAR) && (res.distance <= DIST_FAR), "distance outside 5 to 200 mm")
  `IDAL_ASSERT_SAME(a_zero_far, res_valid && (res.avg == '0), res.distance == DIST_FAR, "zero reading not reported as far")
  `IDAL_ASSERT_SAME(a_flags_excl, vld[ST_B], !(sb.near && sb.far), "segment both near and far")

endmodule

`default_nettype wire

FILE: rtl/ir_distance_average_lut.sv
// ir distance top: per-sensor averaging, apb curve select, interpolation pipeline
// throughput: one sample pair per cycle; ready drops only once the pipeline backs up
// the pipeline is 12 registers deep: 2 for averaging, 10 in the lookup and fraction divider
// reset (sync, active high) clears sums, pair counts and stage valids; curve map resets to 8
`default_nettype none
`include "ir_distance_average_lut_defines.svh"

module ir_distance_average_lut
  import idal_pkg::*;
#(
  parameter int SAMPLE_COUNT = 16,
  parameter int ADC_BITS     = 12,
  parameter int NUM_SENSORS  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // sample pair requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SID_W-1:0]      sensor_id,
  input  logic [ADC_BITS-1:0]   ambient_sample,
  input  logic [ADC_BITS-1:0]   lit_sample,
  // distance results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SID_W-1:0]      result_sensor,
  output logic [DIST_W-1:0]     distance_sixteenths_mm,
  output logic [AVG_W-1:0]      averaged_reading
);

  // pair counter and running sum widths
  localparam int CNT_W     = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);
  localparam int SUM_W     = ADC_BITS + 1 + $clog2(SAMPLE_COUNT);
  // average = floor(sum * 16 / SAMPLE_COUNT) by exact reciprocal multiply
  localparam int SCALED_W  = SUM_W + 3;
  localparam int DIV_SH    = SCALED_W + $clog2(SAMPLE_COUNT);
  localparam int RECIP_W   = SCALED_W + 1;
  localparam int PROD_W    = SCALED_W + RECIP_W;
  localparam int QUO_W     = PROD_W - DIV_SH;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

  // configuration register
  logic             curve_select_map;
  logic [CFG_W-1:0] curve_map;
  logic             cfg_wr;
  logic             reg_hit;

  // per-sensor accumulators, read through wires
  logic signed [SUM_W-1:0] sum_rd [NUM_SLOTS];
  logic        [CNT_W-1:0] cnt_rd [NUM_SLOTS];

  // accept stage
  logic                    accept;
  logic                    sensor_ok;
  logic                    complete;
  logic signed [ADC_BITS:0] diff;
  logic signed [SUM_W-1:0] sum_sel;
  logic        [CNT_W-1:0] cnt_sel;
  logic signed [SUM_W-1:0] sum_next;

  // stage 1: completed sum
  logic                    s1_vld;
  logic [SID_W-1:0]        s1_sensor;
  logic signed [SUM_W-1:0] s1_sum;
  logic                    load1;

  // stage 2: scaled average
  logic                    s2_vld;
  logic [SID_W-1:0]        s2_sensor;
  logic [AVG_W-1:0]        s2_avg;
  logic                    load2;
  logic [SUM_W-2:0]        pos;
  logic [SCALED_W-1:0]     scaled;
  logic [PROD_W-1:0]       prod;
  logic [QUO_W-1:0]        quo;
  logic [AVG_W-1:0]        avg_next;

  interp_req_t             req;
  logic                    req_ready;
  result_t                 res;

  // ---------------------------------------------------------------------------
  // apb: single register, word index in paddr above the byte lane bits
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_CURVE_SELECT);
  assign curve_select_map = cfg_wr && reg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_map <= CURVE_MAP_RESET;
    end else if (curve_select_map) begin
      curve_map <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DATA_W'(curve_map) : '0;

  // ---------------------------------------------------------------------------
  // accumulate the lit minus ambient difference for the addressed sensor
  // ---------------------------------------------------------------------------
  assign accept    = in_valid && in_ready;
  assign sensor_ok = (32'(sensor_id) < 32'(NUM_SENSORS));
  assign diff      = $signed({1'b0, lit_sample}) - $signed({1'b0, ambient_sample});
  assign sum_sel   = sum_rd[sensor_id];
  assign cnt_sel   = cnt_rd[sensor_id];
  assign sum_next  = sum_sel + SUM_W'(diff);
  // last pair of the window for a sensor that exists
  assign complete  = sensor_ok && (cnt_sel == CNT_LAST);

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    if (k < NUM_SENSORS) begin : g_used
      logic signed [SUM_W-1:0] sum;
      logic        [CNT_W-1:0] cnt;

      always_ff @(posedge clk) begin
        if (rst) begin
          sum <= '0;
          cnt <= '0;
        end else if (accept && (sensor_id == SID_W'(k))) begin
          if (complete) begin
            sum <= '0;
            cnt <= '0;
          end else begin
            sum <= sum_next;
            cnt <= cnt_sel + CNT_W'(1);
          end
        end
      end

      assign sum_rd[k] = sum;
      assign cnt_rd[k] = cnt;
    end else begin : g_absent
      // no such sensor: pairs addressed here are dropped
      assign sum_rd[k] = '0;
      assign cnt_rd[k] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // two front stages, moving only where the next stage has room
  // ---------------------------------------------------------------------------
  assign load2    = !s2_vld || req_ready;
  assign load1    = !s1_vld || load2;
  assign in_ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      if (load1) begin
        s1_vld <= accept && complete;
      end
      if (load2) begin
        s2_vld <= s1_vld;
      end
    end
  end

  // negative sums clamp to zero, then scale to q.4 and saturate
  always_comb begin
    pos      = s1_sum[SUM_W-1] ? '0 : s1_sum[SUM_W-2:0];
    scaled   = {pos, 4'b0000};
    prod     = PROD_W'(scaled) * PROD_W'(AVG_RECIP);
    quo      = prod[PROD_W-1:DIV_SH];
    avg_next = (32'(quo) > 32'd65535) ? '1 : AVG_W'(quo);
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_sensor <= sensor_id;
      s1_sum    <= sum_next;
    end
    if (load2) begin
      s2_sensor <= s1_sensor;
      s2_avg    <= avg_next;
    end
  end

  // ---------------------------------------------------------------------------
  // curve lookup and interpolation
  // ---------------------------------------------------------------------------
  assign req.sensor = s2_sensor;
  assign req.avg    = s2_avg;
  assign req.second = curve_map[s2_sensor];

  idal_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s2_vld),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign result_sensor          = res.sensor;
  assign distance_sixteenths_mm = res.distance;
  assign averaged_reading       = res.avg;

  `IDAL_ASSERT_NEXT(a_cfg_write, curve_select_map, curve_map == $past(pwdata[CFG_W-1:0]), "curve map write lost")
  `IDAL_ASSERT_NEXT(a_complete_push, accept && complete, s1_vld && (s1_sensor == $past(sensor_id)), "completed window not queued")
  `IDAL_ASSERT_SAME(a_s1_sensor_ok, s1_vld, 32'(s1_sensor) < 32'(NUM_SENSORS), "result for absent sensor")

endmodule

`default_nettype wire
